// File: hdl/udf_pkg.sv
// shared types, constants and helpers for the unsigned decimal field formatter
package udf_pkg;

  localparam int MaxField  = 63;
  localparam int ValueW    = 32;
  localparam int FieldW    = 6;
  localparam int CharW     = 8;
  localparam int DigitW    = 4;
  localparam int NumDigits = 10;
  localparam int BcdW      = NumDigits * DigitW;
  localparam int LenW      = $clog2(NumDigits + 1);
  localparam int ConvCntW  = $clog2(ValueW);

  localparam logic [CharW-1:0] CharSpace = 8'h20;
  localparam logic [CharW-1:0] CharZero  = 8'h30;

  // format flags of one conversion
  typedef struct packed {
    logic [FieldW-1:0] width;
    logic              prec_given;
    logic [FieldW-1:0] prec;
    logic              left;
    logic              zpad;
  } fmt_t;

  function automatic logic [FieldW-1:0] sat_field(input logic [FieldW-1:0] v);
    logic [FieldW-1:0] lim;
    lim = FieldW'(MaxField);
    return (v > lim) ? lim : v;
  endfunction

endpackage

// File: hdl/udf_bcd.sv
// bit-serial binary to bcd converter (shift and add-3), one input bit per cycle
module udf_bcd (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [udf_pkg::ValueW-1:0] value_i,
  output logic                       done_o,
  output logic [udf_pkg::BcdW-1:0]   bcd_o,
  output logic [udf_pkg::LenW-1:0]   ndig_o,
  output logic                       zero_o
);
  import udf_pkg::*;

  logic                busy_q, busy_d;
  logic                done_q, done_d;
  logic [ConvCntW-1:0] cnt_q, cnt_d;
  logic [ValueW-1:0]   bin_q, bin_d;
  logic [BcdW-1:0]     bcd_q, bcd_d;
  logic [BcdW-1:0]     adj;

  // add 3 to every digit of 5 or more before the shift
  always_comb begin
    for (int i = 0; i < NumDigits; i++) begin
      adj[i*DigitW +: DigitW] = (bcd_q[i*DigitW +: DigitW] >= DigitW'(5)) ?
          bcd_q[i*DigitW +: DigitW] + DigitW'(3) : bcd_q[i*DigitW +: DigitW];
    end
  end

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    bin_d  = bin_q;
    bcd_d  = bcd_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      bin_d  = value_i;
      bcd_d  = '0;
    end else if (busy_q) begin
      bcd_d = {adj[BcdW-2:0], bin_q[ValueW-1]};
      bin_d = {bin_q[ValueW-2:0], 1'b0};
      cnt_d = cnt_q + ConvCntW'(1);
      if (cnt_q == ConvCntW'(ValueW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bin_q <= bin_d;
    bcd_q <= bcd_d;
  end

  // significant digit count, at least one
  always_comb begin
    ndig_o = LenW'(1);
    for (int i = 0; i < NumDigits; i++) begin
      if (bcd_q[i*DigitW +: DigitW] != '0) ndig_o = LenW'(i + 1);
    end
  end

  assign zero_o = (bcd_q == '0);
  assign bcd_o  = bcd_q;
  assign done_o = done_q;

endmodule

// File: hdl/udf_emit.sv
// field layout and character sequencer with registered output
module udf_emit (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [udf_pkg::BcdW-1:0]   bcd_i,
  input  logic [udf_pkg::LenW-1:0]   len_i,
  input  udf_pkg::fmt_t              fmt_i,
  output logic                       done_o,
  output logic                       valid_o,
  input  logic                       stall_i,
  output logic [udf_pkg::CharW-1:0]  character_o,
  output logic                       last_char_o,
  output logic [udf_pkg::FieldW-1:0] total_count_o
);
  import udf_pkg::*;

  typedef enum logic [2:0] {
    E_IDLE  = 3'b001,
    E_SETUP = 3'b010,
    E_RUN   = 3'b100
  } emit_state_e;

  emit_state_e       state_q, state_d;
  fmt_t              fmt_q;
  logic [LenW-1:0]   len_q;
  logic [DigitW-1:0] dig_mem_q [NumDigits];
  logic [FieldW-1:0] pad_q, pad_d;
  logic [FieldW-1:0] zero_q, zero_d;
  logic [LenW-1:0]   dig_q, dig_d;
  logic [FieldW-1:0] rem_q, rem_d;
  logic [FieldW-1:0] total_q, total_d;
  logic              ov_q, ov_d;
  logic [CharW-1:0]  ch_q, ch_d;
  logic              last_q, last_d;
  logic [FieldW-1:0] tc_q, tc_d;
  logic              done_d;

  // layout arithmetic
  logic [FieldW-1:0] len_w, zeros_c, body_c, pad_c;
  logic              zfill;
  logic              load;
  logic [LenW-1:0]   dig_idx;

  always_comb begin
    len_w   = FieldW'(len_q);
    zeros_c = (fmt_q.prec_given && fmt_q.prec > len_w) ? fmt_q.prec - len_w : '0;
    body_c  = len_w + zeros_c;
    pad_c   = (fmt_q.width > body_c) ? fmt_q.width - body_c : '0;
    zfill   = fmt_q.zpad && !fmt_q.prec_given && !fmt_q.left;
  end

  assign load    = !ov_q || !stall_i;
  assign dig_idx = dig_q - LenW'(1);

  always_comb begin
    state_d = state_q;
    pad_d   = pad_q;
    zero_d  = zero_q;
    dig_d   = dig_q;
    rem_d   = rem_q;
    total_d = total_q;
    ov_d    = ov_q && stall_i;
    ch_d    = ch_q;
    last_d  = last_q;
    tc_d    = tc_q;
    done_d  = 1'b0;
    case (state_q)
      E_IDLE: begin
        if (start_i) state_d = E_SETUP;
      end
      E_SETUP: begin
        pad_d   = zfill ? '0 : pad_c;
        zero_d  = zfill ? zeros_c + pad_c : zeros_c;
        dig_d   = len_q;
        rem_d   = body_c + pad_c;
        total_d = body_c + pad_c;
        state_d = E_RUN;
      end
      E_RUN: begin
        if (rem_q == '0) begin
          done_d  = 1'b1;
          state_d = E_IDLE;
        end else if (load) begin
          ov_d   = 1'b1;
          tc_d   = total_q;
          last_d = (rem_q == FieldW'(1));
          rem_d  = rem_q - FieldW'(1);
          if (!fmt_q.left && pad_q != '0) begin
            ch_d  = CharSpace;
            pad_d = pad_q - FieldW'(1);
          end else if (zero_q != '0) begin
            ch_d   = CharZero;
            zero_d = zero_q - FieldW'(1);
          end else if (dig_q != '0) begin
            ch_d  = CharZero | CharW'(dig_mem_q[dig_idx]);
            dig_d = dig_q - LenW'(1);
          end else begin
            ch_d  = CharSpace;
            pad_d = pad_q - FieldW'(1);
          end
        end
      end
      default: state_d = E_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= E_IDLE;
      ov_q    <= 1'b0;
      rem_q   <= '0;
    end else begin
      state_q <= state_d;
      ov_q    <= ov_d;
      rem_q   <= rem_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pad_q   <= pad_d;
    zero_q  <= zero_d;
    dig_q   <= dig_d;
    total_q <= total_d;
    ch_q    <= ch_d;
    last_q  <= last_d;
    tc_q    <= tc_d;
    if (start_i && state_q == E_IDLE) begin
      fmt_q <= fmt_i;
      len_q <= len_i;
      for (int i = 0; i < NumDigits; i++) begin
        dig_mem_q[i] <= bcd_i[i*DigitW +: DigitW];
      end
    end
  end

  assign done_o        = done_d;
  assign valid_o       = ov_q;
  assign character_o   = ch_q;
  assign last_char_o   = last_q;
  assign total_count_o = tc_q;

endmodule

// File: hdl/unsigned_decimal_field_formatter.sv
// top level of the printf style unsigned decimal field formatter
// Prints one 32-bit unsigned value as printf "%u" text with field width,
// optional precision and the minus and zero flags, one ASCII character per
// output transfer, with last_char_o on the final character and total_count_o
// (the character count of the whole conversion) on every one. A zero value
// with precision zero prints no digits, and if the field is then empty the
// conversion produces no transfer at all. Left justify wins over zero pad,
// and a given precision disables zero pad. An item is accepted, converted
// bit by bit in the bit-serial binary to bcd converter, handed off into the
// layout stage and laid out there; its characters (up to 63) then leave at
// one per cycle while stall_i is low, and a closing step ends the conversion.
// stall_o is held high from the accepting edge until the top state returns
// to idle on the emitter's done, which follows the load of the last
// character into the output register, and the output register lets the next
// value enter while that character still waits to be taken.
module unsigned_decimal_field_formatter (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       valid_i,
  output logic                       stall_o,
  input  logic [udf_pkg::ValueW-1:0] value_i,
  input  logic [udf_pkg::FieldW-1:0] width_i,
  input  logic                       precision_given_i,
  input  logic [udf_pkg::FieldW-1:0] precision_i,
  input  logic                       left_justify_i,
  input  logic                       zero_pad_i,
  output logic                       valid_o,
  input  logic                       stall_i,
  output logic [udf_pkg::CharW-1:0]  character_o,
  output logic                       last_char_o,
  output logic [udf_pkg::FieldW-1:0] total_count_o
);
  import udf_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_CONV = 3'b010,
    ST_EMIT = 3'b100
  } top_state_e;

  top_state_e      state_q, state_d;
  fmt_t            fmt_q;
  logic            accept;
  logic            conv_done;
  logic [BcdW-1:0] bcd;
  logic [LenW-1:0] ndig;
  logic            bcd_zero;
  logic [LenW-1:0] len;
  logic            emit_done;

  // one item in flight from accept until the emitter's done, after its last character is loaded
  assign stall_o = (state_q != ST_IDLE);
  assign accept  = valid_i && !stall_o;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (accept) state_d = ST_CONV;
      ST_CONV: if (conv_done) state_d = ST_EMIT;
      ST_EMIT: if (emit_done) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // format flags, saturated at capture
  always_ff @(posedge clk_i) begin
    if (accept) begin
      fmt_q.width      <= sat_field(width_i);
      fmt_q.prec_given <= precision_given_i;
      fmt_q.prec       <= sat_field(precision_i);
      fmt_q.left       <= left_justify_i;
      fmt_q.zpad       <= zero_pad_i;
    end
  end

  udf_bcd u_bcd (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (accept),
    .value_i (value_i),
    .done_o  (conv_done),
    .bcd_o   (bcd),
    .ndig_o  (ndig),
    .zero_o  (bcd_zero)
  );

  // zero value with explicit zero precision prints no digits
  assign len = (fmt_q.prec_given && fmt_q.prec == '0 && bcd_zero) ? '0 : ndig;

  udf_emit u_emit (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (conv_done),
    .bcd_i         (bcd),
    .len_i         (len),
    .fmt_i         (fmt_q),
    .done_o        (emit_done),
    .valid_o       (valid_o),
    .stall_i       (stall_i),
    .character_o   (character_o),
    .last_char_o   (last_char_o),
    .total_count_o (total_count_o)
  );

endmodule

// File: hdl/udf_chk.sv
// port level checker for the unsigned decimal field formatter, with its bind
module udf_chk (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       valid_i,
  input logic                       stall_o,
  input logic                       valid_o,
  input logic                       stall_i,
  input logic [udf_pkg::CharW-1:0]  character_o,
  input logic                       last_char_o,
  input logic [udf_pkg::FieldW-1:0] total_count_o
);
  import udf_pkg::*;

  // a stalled output transfer keeps its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && stall_i |=> valid_o && $stable(character_o) && $stable(last_char_o)
      && $stable(total_count_o))
    else $error("output payload changed under stall");

  // the count stays the same across the characters of one conversion
  a_count_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !stall_i && !last_char_o |=> $stable(total_count_o))
    else $error("total count changed inside a conversion");

  // no new value enters while a conversion is still being printed
  a_busy_mid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !last_char_o |-> stall_o)
    else $error("input taken in the middle of a conversion");

  // an accepted value holds the input side off on the next cycle
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && !stall_o |=> stall_o)
    else $error("input not held off after a transfer");

  // a printed character belongs to a non-empty field
  a_count_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> total_count_o != '0)
    else $error("character shown with zero total count");

endmodule

bind unsigned_decimal_field_formatter udf_chk u_udf_chk (.*);

// File: tb/unsigned_decimal_field_formatter_test.sv
// self-checking testbench for the unsigned decimal field formatter
module unsigned_decimal_field_formatter_test;
  timeunit 1ns;
  timeprecision 1ps;

  import udf_pkg::*;

  // one conversion request as driven on the input ports
  typedef struct packed {
    logic [ValueW-1:0] value;
    fmt_t              fmt;
  } conv_item_t;

  // one printed character as seen on the output ports
  typedef struct packed {
    logic [CharW-1:0]  character;
    logic              last_char;
    logic [FieldW-1:0] total_count;
  } char_rec_t;

  localparam int unsigned NumRandom  = 400;
  localparam int unsigned IdlePct    = 13;
  localparam int unsigned DrainWait  = 120;   // accept + convert + layout + 63 chars, with margin
  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned ReportMax  = 10;

  logic                 clk_i             = 1'b0;
  logic                 rst_ni            = 1'b0;
  logic                 valid_i           = 1'b0;
  logic                 stall_o;
  logic [ValueW-1:0]    value_i           = '0;
  logic [FieldW-1:0]    width_i           = '0;
  logic                 precision_given_i = 1'b0;
  logic [FieldW-1:0]    precision_i       = '0;
  logic                 left_justify_i    = 1'b0;
  logic                 zero_pad_i        = 1'b0;
  logic                 valid_o;
  logic                 stall_i           = 1'b0;
  logic [CharW-1:0]     character_o;
  logic                 last_char_o;
  logic [FieldW-1:0]    total_count_o;

  conv_item_t   pending_items[$];   // requests not yet put on the input ports
  char_rec_t    expected_chars[$];  // predicted text, oldest character first
  conv_item_t   cur_item;           // request currently held on the input ports

  int unsigned  cycle_cnt    = 0;
  int unsigned  n_accepted   = 0;
  int unsigned  n_empty      = 0;
  int unsigned  n_chars      = 0;
  int unsigned  n_mismatch   = 0;
  bit           calm;

  unsigned_decimal_field_formatter u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .valid_i          (valid_i),
    .stall_o          (stall_o),
    .value_i          (value_i),
    .width_i          (width_i),
    .precision_given_i(precision_given_i),
    .precision_i      (precision_i),
    .left_justify_i   (left_justify_i),
    .zero_pad_i       (zero_pad_i),
    .valid_o          (valid_o),
    .stall_i          (stall_i),
    .character_o      (character_o),
    .last_char_o      (last_char_o),
    .total_count_o    (total_count_o)
  );

  // 4 ns clock
  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // both sides run without idling over a stretch of transfers in the middle
  assign calm = (n_accepted >= 150) && (n_accepted < 230);

  function automatic conv_item_t make_item(input logic [ValueW-1:0] value,
                                           input int unsigned width, input bit pg,
                                           input int unsigned prec, input bit left,
                                           input bit zpad);
    conv_item_t it;
    it.value          = value;
    it.fmt.width      = FieldW'(width);
    it.fmt.prec_given = pg;
    it.fmt.prec       = FieldW'(prec);
    it.fmt.left       = left;
    it.fmt.zpad       = zpad;
    return it;
  endfunction

  // mostly short fields, now and then up to the largest
  function automatic int unsigned random_field();
    return ($urandom_range(3) == 0) ? $urandom_range(63) : $urandom_range(12);
  endfunction

  function automatic conv_item_t random_item();
    logic [ValueW-1:0] v;
    logic [ValueW-1:0] p10;
    int unsigned       k;
    p10 = 1;
    case ($urandom_range(7))
      0: v = '0;
      1: v = $urandom_range(9);
      2: begin
        // just around a power of ten, where the digit count changes
        k = $urandom_range(9);
        repeat (k) p10 = p10 * 10;
        v = p10 + $urandom_range(2) - 1;
      end
      3: v = 32'hFFFF_FFFF - $urandom_range(15);
      4: v = $urandom_range(99999);
      default: v = $urandom;
    endcase
    return make_item(v, random_field(), 1'($urandom_range(1)), random_field(),
                     1'($urandom_range(1)), 1'($urandom_range(1)));
  endfunction

  function automatic void push_char(input logic [CharW-1:0] c, input int unsigned pos,
                                    input int unsigned total);
    char_rec_t r;
    r.character   = c;
    r.last_char   = (pos + 1 == total);
    r.total_count = FieldW'(total);
    expected_chars.push_back(r);
  endfunction

  // printf %u layout: [spaces] zeros digits [spaces]
  function automatic void format_unsigned(input conv_item_t it);
    logic [CharW-1:0]  digit_chars [NumDigits];
    logic [ValueW-1:0] v;
    int unsigned       len;
    int unsigned       zeros;
    int unsigned       body;
    int unsigned       pad;
    int unsigned       total;
    int unsigned       pos;
    len = 0;
    v   = it.value;
    // zero with an explicit zero precision prints no digits at all
    if (!(it.fmt.prec_given && it.fmt.prec == 0 && it.value == 0)) begin
      do begin
        digit_chars[len] = CharZero + CharW'(v % 10);
        len++;
        v = v / 10;
      end while (v != 0 && len < NumDigits);
    end
    zeros = (it.fmt.prec_given && it.fmt.prec > len) ? it.fmt.prec - len : 0;
    body  = len + zeros;
    pad   = (it.fmt.width > body) ? it.fmt.width - body : 0;
    // zero pad only when right justified and no precision is given
    if (it.fmt.zpad && !it.fmt.prec_given && !it.fmt.left) begin
      zeros += pad;
      pad    = 0;
    end
    total = pad + zeros + len;
    if (total == 0) n_empty++;
    pos = 0;
    if (!it.fmt.left) begin
      repeat (pad) begin
        push_char(CharSpace, pos, total);
        pos++;
      end
    end
    repeat (zeros) begin
      push_char(CharZero, pos, total);
      pos++;
    end
    for (int i = len; i > 0; i--) begin
      push_char(digit_chars[i-1], pos, total);
      pos++;
    end
    if (it.fmt.left) begin
      repeat (pad) begin
        push_char(CharSpace, pos, total);
        pos++;
      end
    end
  endfunction

  // input side: predict on each accepted transfer, then offer the next request
  always @(posedge clk_i) begin
    bit accepted;
    if (rst_ni) begin
      accepted = valid_i && !stall_o;
      if (accepted) begin
        format_unsigned(cur_item);
        n_accepted++;
      end
      // a stalled request stays on the ports untouched
      if (!valid_i || accepted) begin
        if (pending_items.size() != 0 && (calm || $urandom_range(99) >= IdlePct)) begin
          cur_item          = pending_items.pop_front();
          value_i           <= cur_item.value;
          width_i           <= cur_item.fmt.width;
          precision_given_i <= cur_item.fmt.prec_given;
          precision_i       <= cur_item.fmt.prec;
          left_justify_i    <= cur_item.fmt.left;
          zero_pad_i        <= cur_item.fmt.zpad;
          valid_i           <= 1'b1;
        end else begin
          valid_i <= 1'b0;
        end
      end
    end
  end

  // output side: compare each accepted character with the oldest prediction
  always @(posedge clk_i) begin
    char_rec_t exp_rec;
    if (rst_ni) begin
      if (valid_o && !stall_i) begin
        n_chars++;
        if (expected_chars.size() == 0) begin
          if (n_mismatch < ReportMax)
            $display("mismatch @%0d: unexpected char 0x%02h last %0b total %0d",
                     cycle_cnt, character_o, last_char_o, total_count_o);
          n_mismatch++;
        end else begin
          exp_rec = expected_chars.pop_front();
          if (character_o !== exp_rec.character || last_char_o !== exp_rec.last_char ||
              total_count_o !== exp_rec.total_count) begin
            if (n_mismatch < ReportMax)
              $display("mismatch @%0d: exp char 0x%02h last %0b total %0d, got 0x%02h %0b %0d",
                       cycle_cnt, exp_rec.character, exp_rec.last_char, exp_rec.total_count,
                       character_o, last_char_o, total_count_o);
            n_mismatch++;
          end
        end
      end
      stall_i <= !calm && ($urandom_range(99) < IdlePct);
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("timeout after %0d cycles, %0d characters still expected",
               cycle_cnt, expected_chars.size());
      $display("unsigned_decimal_field_formatter regression: fail");
      $finish;
    end
  end

  initial begin
    rst_ni = 1'b0;

    // directed: empty fields, zero handling, flag interplay, extremes
    pending_items.push_back(make_item(32'd0, 0, 1'b0, 0, 1'b0, 1'b0));   // plain zero prints '0'
    pending_items.push_back(make_item(32'd0, 0, 1'b1, 0, 1'b0, 1'b0));   // nothing at all
    pending_items.push_back(make_item(32'd0, 5, 1'b1, 0, 1'b0, 1'b1));   // only spaces
    pending_items.push_back(make_item(32'd0, 4, 1'b1, 0, 1'b1, 1'b0));   // only spaces, left
    pending_items.push_back(make_item(32'd0, 6, 1'b0, 0, 1'b0, 1'b1));   // zero padded zero
    pending_items.push_back(make_item(32'd0, 0, 1'b1, 63, 1'b0, 1'b0));  // 63 zeros
    pending_items.push_back(make_item(32'hFFFF_FFFF, 0, 1'b0, 0, 1'b0, 1'b0));
    pending_items.push_back(make_item(32'hFFFF_FFFF, 63, 1'b0, 0, 1'b0, 1'b1));
    pending_items.push_back(make_item(32'hFFFF_FFFF, 63, 1'b0, 0, 1'b1, 1'b0));
    pending_items.push_back(make_item(32'hFFFF_FFFF, 63, 1'b1, 63, 1'b1, 1'b1));
    pending_items.push_back(make_item(32'hFFFF_FFFF, 5, 1'b1, 3, 1'b0, 1'b0));
    pending_items.push_back(make_item(32'd12345, 10, 1'b1, 7, 1'b0, 1'b1)); // precision kills zpad
    pending_items.push_back(make_item(32'd12345, 10, 1'b0, 0, 1'b1, 1'b1)); // left beats zpad
    pending_items.push_back(make_item(32'd42, 8, 1'b1, 4, 1'b1, 1'b1));
    pending_items.push_back(make_item(32'd1, 1, 1'b0, 0, 1'b0, 1'b0));
    pending_items.push_back(make_item(32'd1, 63, 1'b1, 63, 1'b0, 1'b0));
    pending_items.push_back(make_item(32'd9, 2, 1'b0, 0, 1'b0, 1'b1));
    pending_items.push_back(make_item(32'd10, 0, 1'b1, 1, 1'b0, 1'b0));
    pending_items.push_back(make_item(32'd99, 3, 1'b0, 0, 1'b1, 1'b0));
    pending_items.push_back(make_item(32'd999999999, 12, 1'b0, 0, 1'b0, 1'b1));
    pending_items.push_back(make_item(32'd1000000000, 11, 1'b1, 12, 1'b0, 1'b0));
    pending_items.push_back(make_item(32'h8000_0000, 0, 1'b1, 0, 1'b0, 1'b0));

    repeat (NumRandom) pending_items.push_back(random_item());

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // all requests taken and all text seen
    do @(posedge clk_i);
    while (pending_items.size() != 0 || valid_i || expected_chars.size() != 0);
    // room for any stray character after the last prediction
    repeat (DrainWait) @(posedge clk_i);

    $display("covered %0d conversions (%0d printing nothing), %0d characters compared",
             n_accepted, n_empty, n_chars);
    $display("%0d mismatches in %0d cycles", n_mismatch, cycle_cnt);
    if (n_mismatch == 0 && expected_chars.size() == 0) begin
      $display("unsigned_decimal_field_formatter regression: pass");
    end else begin
      $display("unsigned_decimal_field_formatter regression: fail");
    end
    $finish;
  end

endmodule

// File: files.f
hdl/udf_pkg.sv
hdl/udf_bcd.sv
hdl/udf_emit.sv
hdl/unsigned_decimal_field_formatter.sv
hdl/udf_chk.sv
tb/unsigned_decimal_field_formatter_test.sv
